// File: rtl/clms_pkg.sv
package clms_pkg;

    // Alphabet and character constants
    localparam int ALPHABET_SIZE = 26;
    localparam int BIN_W = 5;
    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(ALPHABET_SIZE - 1);

    // Input item kinds carried on tuser
    localparam logic [1:0] MODE_FIRST  = 2'd0;
    localparam logic [1:0] MODE_SECOND = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic add_first;
        logic add_second;
        logic clear;
        logic idx_clear;
        logic idx_inc;
        logic cnt_load;
        logic cnt_dec;
        logic show_empty;
    } clms_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic any_common;
        logic bin_common;
        logic no_higher;
        logic cnt_one;
        logic idx_last;
    } clms_sts_t;

endpackage

// File: rtl/clms_dp.sv
module clms_dp #(
    parameter int MAX_LEN = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  clms_pkg::clms_cmd_t cmd,
    input  logic [7:0]          symbol,
    output clms_pkg::clms_sts_t sts,
    output logic [7:0]          letter
);
    import clms_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [CNT_W-1:0] first_bins_reg  [ALPHABET_SIZE];
    logic [CNT_W-1:0] second_bins_reg [ALPHABET_SIZE];
    logic [CNT_W-1:0] first_len_reg;
    logic [CNT_W-1:0] second_len_reg;
    logic [BIN_W-1:0] idx_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             is_letter;
    logic [7:0]       sym_off;
    logic [BIN_W-1:0] bin_sel;
    logic             take_first;
    logic             take_second;
    logic [ALPHABET_SIZE-1:0] common_mask;
    logic [CNT_W-1:0] cur_first;
    logic [CNT_W-1:0] cur_second;
    logic [CNT_W-1:0] cur_min;
    logic             higher_found;

    // Decode the incoming byte into a bin number
    assign is_letter = (symbol >= CHAR_A) && (symbol <= CHAR_Z);
    assign sym_off = symbol - CHAR_A;
    assign bin_sel = sym_off[BIN_W-1:0];
    assign take_first = cmd.add_first && is_letter && (first_len_reg < CNT_W'(MAX_LEN));
    assign take_second = cmd.add_second && is_letter && (second_len_reg < CNT_W'(MAX_LEN));

    // Histograms and string lengths
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                first_bins_reg[i] <= '0;
                second_bins_reg[i] <= '0;
            end
            first_len_reg <= '0;
            second_len_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                first_bins_reg[i] <= '0;
                second_bins_reg[i] <= '0;
            end
            first_len_reg <= '0;
            second_len_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                if (take_first && (bin_sel == BIN_W'(i)))
                begin
                    first_bins_reg[i] <= first_bins_reg[i] + 1'b1;
                end
                if (take_second && (bin_sel == BIN_W'(i)))
                begin
                    second_bins_reg[i] <= second_bins_reg[i] + 1'b1;
                end
            end
            if (take_first)
            begin
                first_len_reg <= first_len_reg + 1'b1;
            end
            if (take_second)
            begin
                second_len_reg <= second_len_reg + 1'b1;
            end
        end
    end

    // Bins that both strings hold at least once
    always_comb
    begin
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            common_mask[i] = (first_bins_reg[i] != '0) && (second_bins_reg[i] != '0);
        end
    end

    // Current bin of the walk and its repeat count
    assign cur_first = first_bins_reg[idx_reg];
    assign cur_second = second_bins_reg[idx_reg];
    assign cur_min = (cur_first < cur_second) ? cur_first : cur_second;

    always_comb
    begin
        higher_found = 1'b0;
        for (int i = 0; i < ALPHABET_SIZE; i++)
        begin
            if ((BIN_W'(i) > idx_reg) && common_mask[i])
            begin
                higher_found = 1'b1;
            end
        end
    end

    // Walk index and remaining repeats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.cnt_load)
            begin
                cnt_reg <= cur_min;
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign sts.any_common = |common_mask;
    assign sts.bin_common = common_mask[idx_reg];
    assign sts.no_higher = !higher_found;
    assign sts.cnt_one = (cnt_reg == CNT_W'(1));
    assign sts.idx_last = (idx_reg == LAST_BIN);

    assign letter = cmd.show_empty ? 8'h00 : (CHAR_A + 8'(idx_reg));

    // Checks on the datapath
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= CNT_W'(MAX_LEN)) && (second_len_reg <= CNT_W'(MAX_LEN)))
        else $error("string length exceeds its cap");

    a_dec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (cnt_reg != '0))
        else $error("repeat count decremented below zero");

    a_clear_lengths: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (first_len_reg == '0) && (second_len_reg == '0))
        else $error("lengths not cleared after finish");

endmodule

// File: rtl/clms_ctrl.sv
module clms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          mode,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                empty_res,
    output logic                last,
    output clms_pkg::clms_cmd_t cmd,
    input  clms_pkg::clms_sts_t sts
);
    import clms_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_EMPTY = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        empty_res = 1'b0;
        last = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (mode)
                        MODE_FIRST:  cmd.add_first = 1'b1;
                        MODE_SECOND: cmd.add_second = 1'b1;
                        MODE_FINISH:
                        begin
                            cmd.idx_clear = 1'b1;
                            state_next = sts.any_common ? ST_SCAN : ST_EMPTY;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (sts.bin_common)
                begin
                    cmd.cnt_load = 1'b1;
                    state_next = ST_EMIT;
                end
                else if (sts.idx_last)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                last = sts.cnt_one && sts.no_higher;
                if (m_tready)
                begin
                    cmd.cnt_dec = 1'b1;
                    if (sts.cnt_one)
                    begin
                        if (sts.no_higher)
                        begin
                            cmd.clear = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_EMPTY:
            begin
                m_tvalid = 1'b1;
                empty_res = 1'b1;
                last = 1'b1;
                cmd.show_empty = 1'b1;
                if (m_tready)
                begin
                    cmd.clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks on the controller
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result beat is offered");

    a_finish_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (mode == MODE_FINISH)) |=> !s_tready)
        else $error("finish item did not start the walk");

endmodule

// File: rtl/common_letter_multiset_sorted_top.sv
// Letter bytes (tuser 0 or 1) are taken one per cycle and leave no result.
// A finish item scans the 26 bins in alphabetical order up to the last common
// bin and sends each common letter min(count1, count2) times as result beats.
// No input is taken while a finish run is being walked and sent.
// Asynchronous active-low reset clears both histograms, lengths and the FSM.
module common_letter_multiset_sorted_top #(
    parameter int MAX_LEN = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] symbol
    input  logic [1:0] s_tuser,  // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // [7:0] letter
    output logic [0:0] m_tuser,  // [0] empty_res
    output logic       m_tlast
);
    import clms_pkg::*;

    clms_cmd_t  cmd;
    clms_sts_t  sts;
    logic       empty_flag;

    // Sequencer for loading and walking the histograms
    clms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .mode      (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .empty_res (empty_flag),
        .last      (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Histograms, walk index and repeat counter
    clms_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .symbol (s_tdata),
        .sts    (sts),
        .letter (m_tdata)
    );

    assign m_tuser[0] = empty_flag;

endmodule

// File: tb/common_letter_multiset_sorted_top_tb.sv
`timescale 1ns / 100ps

module common_letter_multiset_sorted_top_tb;

    import clms_pkg::*;

    localparam int MAX_LEN      = 64;
    localparam int ITEM_BUDGET  = 350;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;

    // The package names only the three live modes; the fourth is ignored by the block.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [7:0] letter;
        logic       empty_res;
        logic       last;
    } overlap_beat_t;

    // Tracks both letter histograms and holds the result beats still owed by the block.
    class letter_overlap_board;
        logic [6:0]    first_bins[ALPHABET_SIZE];
        logic [6:0]    second_bins[ALPHABET_SIZE];
        int            first_len;
        int            second_len;
        int            cap;
        int            errors;
        overlap_beat_t pending[$];

        function new(int cap_i);
            cap    = cap_i;
            errors = 0;
            clear_histograms();
        endfunction

        function void clear_histograms();
            foreach (first_bins[i])
            begin
                first_bins[i]  = '0;
                second_bins[i] = '0;
            end
            first_len  = 0;
            second_len = 0;
        endfunction

        // Applies one accepted input beat and queues the result beats it causes.
        function void note_input(logic [1:0] mode, logic [7:0] symbol);
            overlap_beat_t run[$];
            overlap_beat_t beat;
            int            common;
            bit            is_letter;
            is_letter = (symbol >= CHAR_A) && (symbol <= CHAR_Z);
            if (mode == MODE_FIRST)
            begin
                if (is_letter && first_len < cap)
                begin
                    first_bins[symbol - CHAR_A]++;
                    first_len++;
                end
            end
            else if (mode == MODE_SECOND)
            begin
                if (is_letter && second_len < cap)
                begin
                    second_bins[symbol - CHAR_A]++;
                    second_len++;
                end
            end
            else if (mode == MODE_FINISH)
            begin
                // Walk the bins alphabetically, each letter min(count1, count2) times.
                for (int i = 0; i < ALPHABET_SIZE; i++)
                begin
                    common = (first_bins[i] < second_bins[i]) ? first_bins[i] : second_bins[i];
                    for (int j = 0; j < common && run.size() < cap; j++)
                    begin
                        beat.letter    = CHAR_A + 8'(i);
                        beat.empty_res = 1'b0;
                        beat.last      = 1'b0;
                        run.push_back(beat);
                    end
                end
                if (run.size() == 0)
                begin
                    beat.letter    = 8'd0;
                    beat.empty_res = 1'b1;
                    beat.last      = 1'b1;
                    run.push_back(beat);
                end
                else
                begin
                    run[run.size() - 1].last = 1'b1;
                end
                foreach (run[i])
                    pending.push_back(run[i]);
                clear_histograms();
            end
        endfunction

        // Compares one accepted result beat with the oldest one owed.
        function void check_result(logic [7:0] letter, logic empty_res, logic last);
            overlap_beat_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: letter %0h empty_res %0b last %0b",
                       letter, empty_res, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (letter !== want.letter)
            begin
                $error("letter: expected %0h, actual %0h", want.letter, letter);
                errors++;
            end
            if (empty_res !== want.empty_res)
            begin
                $error("empty_res: expected %0b, actual %0b", want.empty_res, empty_res);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] symbol
    logic [1:0] s_tuser;   // [1:0] mode
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] letter
    logic [0:0] m_tuser;   // [0] empty_res
    logic       m_tlast;

    letter_overlap_board sb;

    int tx_idle_pct;
    int rx_idle_pct;
    int random_beats;
    int in_beats;
    int finish_beats;
    int ignored_beats;
    int out_beats;
    int empty_runs;
    int run_len;
    int longest_run;
    int quiet_cycles;

    common_letter_multiset_sorted_top #(
        .MAX_LEN (MAX_LEN)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Free-running 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver back-pressure at the current idle rate.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Both handshakes are observed in one place so that an input is always
    // noted before any result it causes is checked. The stall watchdog lives here too.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if (s_tvalid && s_tready)
            begin
                sb.note_input(s_tuser, s_tdata);
                in_beats++;
                if (s_tuser == MODE_FINISH)
                    finish_beats++;
                else if (s_tuser == MODE_UNUSED || s_tdata < CHAR_A || s_tdata > CHAR_Z)
                    ignored_beats++;
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata, m_tuser[0], m_tlast);
                out_beats++;
                run_len++;
                if (m_tuser[0])
                    empty_runs++;
                if (m_tlast)
                begin
                    if (run_len > longest_run)
                        longest_run = run_len;
                    run_len = 0;
                end
                quiet_cycles = 0;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("[common_letter_multiset_sorted_top] ERROR");
                $finish;
            end
        end
    end

    // Presents one input beat, idling beforehand at the current rate. Valid stays
    // high afterwards so back-to-back beats need no second assignment in one step.
    task automatic send_item(input logic [1:0] mode, input logic [7:0] symbol);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= symbol;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // Holds the sender back until every owed result beat has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // One well-formed pair of strings followed by a finish. Letters come from the
    // range lo..hi so that the strings overlap often; a few beats are noise.
    task automatic send_frame(input int n, input int lo, input int hi);
        logic [1:0] mode;
        logic [7:0] symbol;
        repeat (n)
        begin
            mode   = $urandom_range(0, 1) ? MODE_SECOND : MODE_FIRST;
            symbol = CHAR_A + 8'($urandom_range(lo, hi));
            if ($urandom_range(0, 99) < 8)
                symbol = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 3)
                mode = MODE_UNUSED;
            send_item(mode, symbol);
            random_beats++;
        end
        send_item(MODE_FINISH, 8'($urandom_range(0, 255)));
        random_beats++;
    endtask

    initial
    begin
        int lo;
        int hi;
        bit long_done;

        sb            = new(MAX_LEN);
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        random_beats  = 0;
        in_beats      = 0;
        finish_beats  = 0;
        ignored_beats = 0;
        out_beats     = 0;
        empty_runs    = 0;
        run_len       = 0;
        longest_run   = 0;
        quiet_cycles  = 0;
        long_done     = 1'b0;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= MODE_FIRST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: finish on empty histograms gives the single empty beat.
        send_item(MODE_FINISH, 8'h00);
        // Alphabet extremes on both strings.
        send_item(MODE_FIRST,  CHAR_A);
        send_item(MODE_FIRST,  CHAR_Z);
        send_item(MODE_SECOND, CHAR_Z);
        send_item(MODE_SECOND, CHAR_A);
        send_item(MODE_SECOND, CHAR_A);
        // Bytes just outside the letter range and the byte extremes are ignored.
        send_item(MODE_FIRST,  CHAR_A - 8'd1);
        send_item(MODE_SECOND, CHAR_Z + 8'd1);
        send_item(MODE_FIRST,  8'h00);
        send_item(MODE_SECOND, 8'hff);
        send_item(MODE_FIRST,  8'h41);
        // The unused mode changes nothing, even with a letter.
        send_item(MODE_UNUSED, CHAR_A);
        send_item(MODE_UNUSED, 8'hff);
        send_item(MODE_FINISH, 8'hff);
        // Disjoint strings give the empty beat again.
        send_item(MODE_FIRST,  CHAR_A + 8'd1);
        send_item(MODE_SECOND, CHAR_A + 8'd2);
        send_item(MODE_FINISH, CHAR_A);

        // Random frames in three idle phases, with a full drain between phases.
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 53 : 0;
            rx_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 13 : 0;
            while (random_beats < (phase + 1) * ITEM_BUDGET / 3)
            begin
                lo = $urandom_range(0, ALPHABET_SIZE - 1);
                if (!long_done || $urandom_range(0, 14) == 0)
                begin
                    // Both strings overrun the length cap; a single letter gives
                    // the longest possible result run.
                    hi = (!long_done || $urandom_range(0, 1)) ? lo : lo + 2;
                    if (hi > ALPHABET_SIZE - 1)
                        hi = ALPHABET_SIZE - 1;
                    long_done = 1'b1;
                    send_frame(180, lo, hi);
                end
                else
                begin
                    hi = lo + $urandom_range(0, 8);
                    if (hi > ALPHABET_SIZE - 1)
                        hi = ALPHABET_SIZE - 1;
                    send_frame($urandom_range(0, 24), lo, hi);
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending.size() != 0)
        begin
            $error("%0d result beats never arrived", sb.pending.size());
            sb.errors++;
        end

        $display("Sent %0d input beats (%0d finishes, %0d ignored bytes or modes).",
                 in_beats, finish_beats, ignored_beats);
        $display("Checked %0d result beats, %0d empty runs, longest run %0d letters.",
                 out_beats, empty_runs, longest_run);
        if (sb.errors == 0)
        begin
            $display("[common_letter_multiset_sorted_top] OK");
        end
        else
        begin
            $display("[common_letter_multiset_sorted_top] ERROR");
        end
        $finish;
    end

endmodule

// File: common_letter_multiset_sorted_top.f
rtl/clms_pkg.sv
rtl/clms_dp.sv
rtl/clms_ctrl.sv
rtl/common_letter_multiset_sorted_top.sv
tb/common_letter_multiset_sorted_top_tb.sv
